// File: rtl/cpt_pkg.sv
package cpt_pkg;

	localparam int TRAVEL_W   = 10;
	localparam int POS_W      = 10;
	localparam int LEVEL_W    = 7;
	localparam int PCT_W      = 7;
	localparam int PCT_IN_W   = 8;
	localparam int ELAPSED_W  = 13;
	localparam int MUL_W      = 16;
	localparam int DIVIDEND_W = 20;
	localparam int DIV_STEPS  = DIVIDEND_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic [TRAVEL_W-1:0] TRAVEL_RESET = TRAVEL_W'(30);
	localparam logic [TRAVEL_W-1:0] TRAVEL_MAX   = TRAVEL_W'(600);
	localparam logic [POS_W-1:0]    POS_MAX      = POS_W'(1000);
	localparam logic [PCT_IN_W-1:0] PCT_MAX      = PCT_IN_W'(100);

	// operation codes
	localparam logic [1:0] OP_GOTO = 2'd0;
	localparam logic [1:0] OP_STOP = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// direction codes
	localparam logic [1:0] DIR_STOP  = 2'd0;
	localparam logic [1:0] DIR_OPEN  = 2'd1;
	localparam logic [1:0] DIR_CLOSE = 2'd2;

	// goto status codes
	localparam logic [1:0] GS_NONE      = 2'd0;
	localparam logic [1:0] GS_AT_TARGET = 2'd1;
	localparam logic [1:0] GS_OPENING   = 2'd2;
	localparam logic [1:0] GS_CLOSING   = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SCALE,
		S_TENTHS,
		S_DIV,
		S_FINISH,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic load_in;
		logic prep;
		logic scale;
		logic tenths;
		logic div_step;
		logic finish;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} sts_t;

	// x / 10 for x below 1029
	function automatic logic [LEVEL_W-1:0] div10_narrow(input logic [POS_W-1:0] x);
		logic [17:0] p;
		p = {8'd0, x} * 18'd205;
		return p[17:11];
	endfunction

	// x / 10 for any 16-bit x, result kept to the elapsed width
	function automatic logic [ELAPSED_W-1:0] div10_wide(input logic [MUL_W-1:0] x);
		logic [31:0] p;
		p = {16'd0, x} * 32'd52429;
		return p[31:19];
	endfunction

endpackage

// File: rtl/cpt_ctrl.sv
module cpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cpt_pkg::sts_t     sts,
	output cpt_pkg::cmd_t     cmd
);

	cpt_pkg::ctrl_state_t state_q, state_d;
	logic [cpt_pkg::CNT_W-1:0] cnt_q;
	logic div_last;

	assign div_last = (cnt_q == cpt_pkg::CNT_W'(cpt_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpt_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cpt_pkg::S_TENTHS) begin
				cnt_q <= '0;
			end else if (state_q == cpt_pkg::S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpt_pkg::S_IDLE:   if (in_valid) state_d = cpt_pkg::S_PREP;
			cpt_pkg::S_PREP:   state_d = cpt_pkg::S_SCALE;
			cpt_pkg::S_SCALE:  state_d = cpt_pkg::S_TENTHS;
			cpt_pkg::S_TENTHS: state_d = cpt_pkg::S_DIV;
			cpt_pkg::S_DIV:    if (div_last) state_d = cpt_pkg::S_FINISH;
			cpt_pkg::S_FINISH: state_d = cpt_pkg::S_OUT;
			cpt_pkg::S_OUT:    if (!sts.out_full) state_d = cpt_pkg::S_IDLE;
			default:           state_d = cpt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			cpt_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			cpt_pkg::S_PREP:   cmd.prep     = 1'b1;
			cpt_pkg::S_SCALE:  cmd.scale    = 1'b1;
			cpt_pkg::S_TENTHS: cmd.tenths   = 1'b1;
			cpt_pkg::S_DIV:    cmd.div_step = 1'b1;
			cpt_pkg::S_FINISH: cmd.finish   = 1'b1;
			cpt_pkg::S_OUT:    cmd.out_load = !sts.out_full;
			default: ;
		endcase
	end

endmodule

// File: rtl/cpt_datapath.sv
module cpt_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cpt_pkg::cmd_t                     cmd,
	output cpt_pkg::sts_t                     sts,
	input  logic                              cfg_we,
	input  logic [cpt_pkg::TRAVEL_W-1:0]      cfg_data,
	input  logic [1:0]                        operation,
	input  logic [cpt_pkg::PCT_IN_W-1:0]      goal_pct,
	output logic [cpt_pkg::POS_W-1:0]         position_x10,
	output logic [cpt_pkg::LEVEL_W-1:0]       level_pct,
	output logic [1:0]                        move_dir,
	output logic                              motor_on,
	output logic                              report_valid,
	output logic [1:0]                        goto_status,
	output logic                              out_valid,
	input  logic                              out_ready
);

	// block state
	logic [cpt_pkg::TRAVEL_W-1:0]   travel_q;
	logic [cpt_pkg::ELAPSED_W-1:0]  elapsed_q;
	logic [1:0]                     dir_q;
	logic [cpt_pkg::PCT_W-1:0]      target_q;
	logic [cpt_pkg::POS_W-1:0]      pos_q;
	logic                           motor_q;

	// per-transaction working registers
	logic [1:0]                     op_q;
	logic [cpt_pkg::PCT_W-1:0]      pct_q;
	logic                           act_q;
	logic [cpt_pkg::LEVEL_W-1:0]    cur_q;
	logic [cpt_pkg::MUL_W-1:0]      mul_q;
	logic                           rem0_q;
	logic [cpt_pkg::ELAPSED_W-1:0]  tds_q;
	logic [cpt_pkg::TRAVEL_W-1:0]   rem_q;
	logic [cpt_pkg::DIVIDEND_W-1:0] quo_q;
	logic                           report_q;
	logic [1:0]                     status_q;

	// output register
	logic [cpt_pkg::POS_W-1:0]      out_pos_q;
	logic [cpt_pkg::LEVEL_W-1:0]    out_level_q;
	logic [1:0]                     out_dir_q;
	logic                           out_motor_q;
	logic                           out_report_q;
	logic [1:0]                     out_status_q;
	logic                           out_valid_q;

	logic [cpt_pkg::TRAVEL_W-1:0]   t_eff;
	logic [cpt_pkg::ELAPSED_W-1:0]  max_ds;
	logic                           act;
	logic [cpt_pkg::PCT_W-1:0]      sel_pct;
	logic [cpt_pkg::ELAPSED_W-1:0]  e_div10;
	logic [cpt_pkg::TRAVEL_W:0]     trial;
	logic                           trial_ge;
	logic [cpt_pkg::POS_W-1:0]      pos_div;
	logic                           at_limit;
	logic                           at_target;
	logic                           going_up;

	assign t_eff   = (travel_q > cpt_pkg::TRAVEL_MAX) ? cpt_pkg::TRAVEL_MAX : travel_q;
	assign max_ds  = cpt_pkg::ELAPSED_W'({3'd0, t_eff} * 13'd10);
	assign act     = (op_q == cpt_pkg::OP_TICK) && motor_q && (dir_q != cpt_pkg::DIR_STOP);
	assign sel_pct = (op_q == cpt_pkg::OP_GOTO) ? cur_q : target_q;
	assign e_div10 = cpt_pkg::div10_wide({3'd0, elapsed_q});

	// restoring divider step: elapsed * 100 / travel
	assign trial    = {rem_q, quo_q[cpt_pkg::DIVIDEND_W-1]};
	assign trial_ge = (trial >= {1'b0, t_eff});

	assign pos_div = (t_eff == '0) ? '0 :
		(quo_q > cpt_pkg::DIVIDEND_W'(cpt_pkg::POS_MAX)) ? cpt_pkg::POS_MAX :
		quo_q[cpt_pkg::POS_W-1:0];

	assign at_limit  = (dir_q == cpt_pkg::DIR_OPEN) ? (elapsed_q >= max_ds) : (elapsed_q == '0);
	assign at_target = (dir_q == cpt_pkg::DIR_OPEN) ? (elapsed_q >= tds_q) : (elapsed_q <= tds_q);
	assign going_up  = (pct_q > cur_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q  <= cpt_pkg::TRAVEL_RESET;
			elapsed_q <= '0;
			dir_q     <= cpt_pkg::DIR_STOP;
			target_q  <= '0;
			pos_q     <= '0;
			motor_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				travel_q <= cfg_data;
			end
			if (cmd.prep && act) begin
				if (dir_q == cpt_pkg::DIR_OPEN && elapsed_q < max_ds) begin
					elapsed_q <= elapsed_q + 1'b1;
				end else if (dir_q == cpt_pkg::DIR_CLOSE && elapsed_q != '0) begin
					elapsed_q <= elapsed_q - 1'b1;
				end
			end
			if (cmd.finish) begin
				case (op_q)
					cpt_pkg::OP_GOTO: begin
						if (cur_q != pct_q) begin
							dir_q     <= going_up ? cpt_pkg::DIR_OPEN : cpt_pkg::DIR_CLOSE;
							target_q  <= pct_q;
							elapsed_q <= tds_q;
							motor_q   <= 1'b1;
						end
					end
					cpt_pkg::OP_STOP: begin
						dir_q   <= cpt_pkg::DIR_STOP;
						motor_q <= 1'b0;
					end
					cpt_pkg::OP_TICK: begin
						if (act_q) begin
							if (at_limit || at_target) begin
								dir_q   <= cpt_pkg::DIR_STOP;
								motor_q <= 1'b0;
							end
							if (at_target && !at_limit) begin
								// snap to the exact target
								elapsed_q <= tds_q;
								pos_q     <= cpt_pkg::POS_W'({3'd0, target_q} * 10'd10);
							end else begin
								pos_q <= pos_div;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= operation;
			pct_q <= (goal_pct > cpt_pkg::PCT_MAX) ? cpt_pkg::PCT_MAX[cpt_pkg::PCT_W-1:0] :
				goal_pct[cpt_pkg::PCT_W-1:0];
		end
		if (cmd.prep) begin
			act_q <= act;
			cur_q <= cpt_pkg::div10_narrow(pos_q);
		end
		if (cmd.scale) begin
			mul_q  <= cpt_pkg::MUL_W'({9'd0, sel_pct} * {6'd0, t_eff});
			rem0_q <= (elapsed_q == cpt_pkg::ELAPSED_W'(e_div10 * 13'd10));
		end
		if (cmd.tenths) begin
			tds_q <= cpt_pkg::div10_wide(mul_q);
			quo_q <= cpt_pkg::DIVIDEND_W'({7'd0, elapsed_q} * 20'd100);
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? cpt_pkg::TRAVEL_W'(trial - {1'b0, t_eff}) :
				trial[cpt_pkg::TRAVEL_W-1:0];
			quo_q <= {quo_q[cpt_pkg::DIVIDEND_W-2:0], trial_ge};
		end
		if (cmd.finish) begin
			case (op_q)
				cpt_pkg::OP_GOTO: begin
					report_q <= 1'b0;
					if (cur_q == pct_q) begin
						status_q <= cpt_pkg::GS_AT_TARGET;
					end else begin
						status_q <= going_up ? cpt_pkg::GS_OPENING : cpt_pkg::GS_CLOSING;
					end
				end
				cpt_pkg::OP_TICK: begin
					report_q <= act_q && (rem0_q || (at_target && !at_limit));
					status_q <= cpt_pkg::GS_NONE;
				end
				default: begin
					report_q <= 1'b0;
					status_q <= cpt_pkg::GS_NONE;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_pos_q    <= pos_q;
			out_level_q  <= cpt_pkg::div10_narrow(pos_q);
			out_dir_q    <= dir_q;
			out_motor_q  <= motor_q;
			out_report_q <= report_q;
			out_status_q <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_full = out_valid_q && !out_ready;

	assign position_x10 = out_pos_q;
	assign level_pct    = out_level_q;
	assign move_dir     = out_dir_q;
	assign motor_on     = out_motor_q;
	assign report_valid = out_report_q;
	assign goto_status  = out_status_q;
	assign out_valid    = out_valid_q;

endmodule

// File: rtl/cover_position_tracker_unit.sv
// Time-based position tracker for a motorized cover. Each accepted transaction (goto, stop,
// 100 ms tick or the unused code) yields exactly one result holding the state after it. Most
// of the time from acceptance until the next one can be accepted goes to the 20-step
// restoring divider that turns elapsed run time into a position (elapsed * 100 /
// travel). The input side is free again as soon as the result sits in the output register,
// so a result waiting on out_ready only holds the next transaction at its final cycle. The
// travel time register (reset 30 s, values above 600 act as 600) is written through the cfg
// channel, by the user only while no transaction is in flight; the block does not enforce it.
module cover_position_tracker_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cpt_pkg::TRAVEL_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [cpt_pkg::PCT_IN_W-1:0] goal_pct,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cpt_pkg::POS_W-1:0]    position_x10,
	output logic [cpt_pkg::LEVEL_W-1:0]  level_pct,
	output logic [1:0]                   move_dir,
	output logic                         motor_on,
	output logic                         report_valid,
	output logic [1:0]                   goto_status
);

	cpt_pkg::cmd_t cmd;
	cpt_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.goal_pct     (goal_pct),
		.position_x10 (position_x10),
		.level_pct    (level_pct),
		.move_dir     (move_dir),
		.motor_on     (motor_on),
		.report_valid (report_valid),
		.goto_status  (goto_status),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

`ifndef NO_ASSERTIONS
	// motor drive and direction always change together
	a_motor_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (motor_on == (move_dir != cpt_pkg::DIR_STOP)))
		else $error("motor_on disagrees with move_dir");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (position_x10 <= cpt_pkg::POS_MAX))
		else $error("position above full travel");

	// a goto never flags a report
	a_goto_report: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && goto_status != cpt_pkg::GS_NONE) |-> !report_valid)
		else $error("report flagged on goto transaction");

	// a new transaction is only taken with the pipeline empty
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("back-to-back accept");
`endif

endmodule

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cpt_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [LEVEL_W-1:0] level;
		logic [1:0]         dir;
		logic               motor;
		logic               report;
		logic [1:0]         status;
	} cover_state_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [TRAVEL_W-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          operation;
	logic [PCT_IN_W-1:0] goal_pct;
	logic                out_valid;
	logic                out_ready;
	logic [POS_W-1:0]    position_x10;
	logic [LEVEL_W-1:0]  level_pct;
	logic [1:0]          move_dir;
	logic                motor_on;
	logic                report_valid;
	logic [1:0]          goto_status;

	cover_position_tracker_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.goal_pct     (goal_pct),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position_x10 (position_x10),
		.level_pct    (level_pct),
		.move_dir     (move_dir),
		.motor_on     (motor_on),
		.report_valid (report_valid),
		.goto_status  (goto_status)
	);

	// tracker state as the testbench sees it
	logic [ELAPSED_W-1:0] trk_elapsed;
	logic [1:0]           trk_dir;
	logic [PCT_W-1:0]     trk_goal;
	logic [POS_W-1:0]     trk_pos;
	logic                 trk_motor;
	logic [TRAVEL_W-1:0]  trk_travel;

	cover_state_t cover_states_due[$];
	int unsigned  mismatch_count = 0;
	bit           steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int unsigned usable_travel();
		return (trk_travel > TRAVEL_MAX) ? 600 : trk_travel;
	endfunction

	function automatic int unsigned percent_to_run(input int unsigned pct);
		int unsigned t;
		t = usable_travel();
		if (t == 0)
			return 0;
		return (pct * t * 10) / 100;
	endfunction

	function automatic int unsigned run_to_position(input int unsigned ds);
		int unsigned t;
		int unsigned p;
		t = usable_travel();
		if (t == 0)
			return 0;
		p = (ds * 1000) / (t * 10);
		return (p > 1000) ? 1000 : p;
	endfunction

	function automatic cover_state_t step_cover(input logic [1:0] op,
			input logic [PCT_IN_W-1:0] pct_in);
		int unsigned  pct;
		int unsigned  cur;
		int unsigned  max_ds;
		int unsigned  goal_ds;
		int unsigned  el;
		logic         at_limit;
		logic         at_goal;
		cover_state_t r;
		r = '0;
		r.status = GS_NONE;
		case (op)
			OP_GOTO: begin
				pct = (pct_in > PCT_MAX) ? 100 : pct_in;
				cur = trk_pos / 10;
				if (cur > 100)
					cur = 100;
				if (cur == pct) begin
					r.status = GS_AT_TARGET;
				end else begin
					trk_dir = (pct > cur) ? DIR_OPEN : DIR_CLOSE;
					trk_goal = PCT_W'(pct);
					trk_elapsed = ELAPSED_W'(percent_to_run(cur));
					trk_motor = 1'b1;
					r.status = (trk_dir == DIR_OPEN) ? GS_OPENING : GS_CLOSING;
				end
			end
			OP_STOP: begin
				trk_motor = 1'b0;
				trk_dir = DIR_STOP;
			end
			OP_TICK: begin
				if (trk_motor && trk_dir != DIR_STOP) begin
					max_ds = usable_travel() * 10;
					goal_ds = percent_to_run(trk_goal);
					el = trk_elapsed;
					if (trk_dir == DIR_OPEN && el < max_ds)
						el++;
					else if (trk_dir == DIR_CLOSE && el > 0)
						el--;
					el = el % 8192;
					trk_pos = POS_W'(run_to_position(el));
					if (el % 10 == 0)
						r.report = 1'b1;
					if (trk_dir == DIR_OPEN) begin
						at_limit = (el >= max_ds);
						at_goal = (el >= goal_ds);
					end else begin
						at_limit = (el == 0);
						at_goal = (el <= goal_ds);
					end
					if (at_limit || at_goal) begin
						trk_motor = 1'b0;
						trk_dir = DIR_STOP;
						// stopped short of a limit: snap onto the exact target
						if (!at_limit) begin
							el = goal_ds;
							trk_pos = POS_W'(trk_goal * 10);
							r.report = 1'b1;
						end
					end
					trk_elapsed = ELAPSED_W'(el);
				end
			end
			default: begin
			end
		endcase
		r.position = trk_pos;
		r.level = LEVEL_W'(trk_pos / 10);
		r.dir = trk_dir;
		r.motor = trk_motor;
		return r;
	endfunction

	// result side: random back-pressure bursts
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (steady) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cover_state_t got;
		cover_state_t want;
		if (out_valid && out_ready) begin
			got.position = position_x10;
			got.level = level_pct;
			got.dir = move_dir;
			got.motor = motor_on;
			got.report = report_valid;
			got.status = goto_status;
			if (cover_states_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with none due: pos %0d level %0d dir %0d motor %0b rep %0b st %0d",
						$time, got.position, got.level, got.dir, got.motor, got.report,
						got.status);
			end else begin
				want = cover_states_due.pop_front();
				if (got.position !== want.position || got.level !== want.level ||
						got.dir !== want.dir || got.motor !== want.motor ||
						got.report !== want.report || got.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: expected pos %0d level %0d dir %0d motor %0b rep %0b st %0d",
							$time, want.position, want.level, want.dir, want.motor,
							want.report, want.status);
						$display("%0t: actual   pos %0d level %0d dir %0d motor %0b rep %0b st %0d",
							$time, got.position, got.level, got.dir, got.motor,
							got.report, got.status);
					end
				end
			end
		end
	end

	task automatic reset_dut();
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		operation <= OP_GOTO;
		goal_pct <= '0;
		trk_elapsed = '0;
		trk_dir = DIR_STOP;
		trk_goal = '0;
		trk_pos = '0;
		trk_motor = 1'b0;
		trk_travel = TRAVEL_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	task automatic send_item(input logic [1:0] op, input logic [PCT_IN_W-1:0] pct);
		if (!steady && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		goal_pct <= pct;
		do @(posedge clk); while (!in_ready);
		cover_states_due.push_back(step_cover(op, pct));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (cover_states_due.size() != 0);
	endtask

	task automatic write_travel(input logic [TRAVEL_W-1:0] secs);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= secs;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		trk_travel = secs;
	endtask

	// goto onto the current level, idle tick and the unused code straight after reset
	task automatic test_idle_after_reset();
		send_item(OP_GOTO, 8'd0);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_SPARE, 8'hFF);
	endtask

	// clamped goto runs to the open limit, then a clamped goto there is refused
	task automatic test_full_open_run();
		write_travel(10'd1);
		send_item(OP_GOTO, 8'd255);
		while (trk_motor)
			send_item(OP_TICK, 8'd0);
		send_item(OP_GOTO, 8'd200);
	endtask

	// travel cut while the motor still runs: position saturates at full
	task automatic test_travel_shortened();
		write_travel(10'd60);
		send_item(OP_GOTO, 8'd0);
		send_item(OP_TICK, 8'd0);
		write_travel(10'd6);
		send_item(OP_TICK, 8'd0);
		send_item(OP_STOP, 8'd0);
	endtask

	task automatic test_zero_travel();
		write_travel(10'd0);
		send_item(OP_GOTO, 8'd50);
		send_item(OP_TICK, 8'd0);
		send_item(OP_GOTO, 8'd0);
		send_item(OP_GOTO, 8'd50);
		send_item(OP_TICK, 8'd0);
	endtask

	function automatic logic [TRAVEL_W-1:0] travel_for_phase(input int unsigned phase);
		case (phase)
			0: return 10'd1;
			1: return 10'd2;
			2: return 10'd3;
			3: return 10'd5;
			4: return 10'd0;
			5: return 10'd10;
			6: return 10'd7;
			7: return 10'd1023;
			8: return 10'd4;
			9: return 10'd600;
			default: return TRAVEL_W'($urandom_range(1, 12));
		endcase
	endfunction

	task automatic run_mixed_traffic(input int unsigned quota);
		int unsigned done;
		int unsigned kind;
		int unsigned n;
		logic [PCT_IN_W-1:0] goal;
		done = 0;
		while (done < quota) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				if ($urandom_range(0, 7) == 0)
					goal = PCT_IN_W'($urandom_range(101, 255));
				else
					goal = PCT_IN_W'($urandom_range(0, 100));
				send_item(OP_GOTO, goal);
				done++;
				n = 0;
				// tick the move through, now and then cut short or disturbed
				while (trk_motor && n < 200 && done < quota) begin
					if ($urandom_range(0, 39) == 0) begin
						send_item(OP_STOP, PCT_IN_W'($urandom));
						done++;
					end else if ($urandom_range(0, 59) == 0) begin
						send_item(OP_SPARE, PCT_IN_W'($urandom));
					end else begin
						send_item(OP_TICK, PCT_IN_W'($urandom));
						done++;
					end
					n++;
				end
			end else if (kind == 7) begin
				send_item(OP_STOP, PCT_IN_W'($urandom));
				done++;
			end else if (kind == 8) begin
				if ($urandom_range(0, 1) == 0)
					send_item(OP_SPARE, PCT_IN_W'($urandom));
				else
					send_item(OP_TICK, PCT_IN_W'($urandom));
			end else begin
				send_item(OP_GOTO, PCT_IN_W'(trk_pos / 10));
				done++;
			end
		end
	endtask

	task automatic test_random_runs();
		int unsigned phase;
		for (phase = 0; phase < 11; phase++) begin
			write_travel(travel_for_phase(phase));
			steady = ($urandom_range(0, 3) == 0);
			run_mixed_traffic(160);
		end
	endtask

	task automatic test_steady_stream();
		write_travel(TRAVEL_W'($urandom_range(1, 6)));
		steady = 1'b1;
		run_mixed_traffic(100);
	endtask

	initial begin
		reset_dut();
		test_idle_after_reset();
		test_full_open_run();
		test_travel_shortened();
		test_zero_travel();
		test_random_runs();
		test_steady_stream();
		drain_results();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && cover_states_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
